// ----- src/wpd_pkg.sv -----
// Shared types, constants and the header check for the WAV PCM stream decoder.
// Used by the controller, the datapath, the divider and the top level; depends on nothing.
`default_nettype none

package wpd_pkg;

   localparam int unsigned POS_W        = 6;
   localparam int unsigned HDR_LAST_POS = 43;
   localparam int unsigned FMT_SIZE_POS = 16;
   localparam int unsigned FMT_CODE_POS = 20;
   localparam int unsigned CHAN_POS     = 22;
   localparam int unsigned RATE_POS     = 24;
   localparam int unsigned ALIGN_POS    = 32;
   localparam int unsigned BITS_POS     = 34;
   localparam int unsigned SIZE_POS     = 40;

   localparam int unsigned FMT_SIZE_MAX = 16;
   localparam int unsigned FORMAT_PCM   = 1;
   localparam int unsigned MAX_CHANNELS = 2;
   localparam int unsigned BITS_NARROW  = 8;
   localparam int unsigned BITS_WIDE    = 16;

   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned DIV_STEPS  = 32;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_ACCEPT = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_SHORT    = 3'd1,
      ERR_FORMAT   = 3'd2,
      ERR_NEG_SIZE = 3'd3,
      ERR_CHANNELS = 3'd4,
      ERR_BITS     = 3'd5,
      ERR_ALIGN    = 3'd6
   } err_type;

   typedef enum logic [1:0] {
      ST_HEADER = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_DATA   = 2'd2,
      ST_DONE   = 2'd3
   } wpd_state_type;

   typedef struct packed {
      logic clear;
      logic hdr_capture;
      logic hdr_result;
      logic short_err;
      logic data_byte;
      logic div_start;
   } wpd_cmd_type;

   typedef struct packed {
      logic out_free;
      logic pos_end;
      logic hdr_ok;
      logic emit_now;
      logic samples_one;
      logic div_busy;
      logic div_done;
      logic count_zero;
   } wpd_status_type;

   function automatic err_type header_check(
      input logic [31:0] fmt_size,
      input logic [15:0] fmt_code,
      input logic [15:0] channels,
      input logic [15:0] bits,
      input logic [15:0] align,
      input logic [31:0] size
   );
      logic fmt_big;
      err_type err;
      fmt_big = !fmt_size[31] && (fmt_size[30:0] > 31'(FMT_SIZE_MAX));
      priority if (fmt_big || fmt_code != 16'(FORMAT_PCM)) err = ERR_FORMAT;
      else if (size[31]) err = ERR_NEG_SIZE;
      else if (channels > 16'(MAX_CHANNELS)) err = ERR_CHANNELS;
      else if (bits != 16'(BITS_NARROW) && bits != 16'(BITS_WIDE)) err = ERR_BITS;
      else if (align == 16'd0) err = ERR_ALIGN;
      else err = ERR_NONE;
      return err;
   endfunction

endpackage

`default_nettype wire

// ----- src/wpd_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, for the frame count.
// Depends on wpd_pkg.
`default_nettype none

module wpd_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [31:0]      quotient
);
   import wpd_pkg::*;

   localparam int unsigned CNT_W = $clog2(DIV_STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      rem_ff, rem_in;
   logic [31:0]      quo_ff, quo_in;
   logic [16:0]      trial;
   logic [16:0]      diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[31]};
      fits    = trial >= {1'b0, divisor};
      diff    = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- src/wpd_datapath.sv -----
// Datapath: header field capture, header check, sample decoding, sample count
// and the result register. Depends on wpd_pkg and wpd_div.
`default_nettype none

module wpd_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire wpd_pkg::wpd_cmd_type             cmd,
   input  wire logic [7:0]                       data_byte,
   input  wire logic                             rsp_tready,
   output wpd_pkg::wpd_status_type               status,
   output logic                                  rsp_tvalid,
   output logic [wpd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [1:0]                            rsp_tuser
);
   import wpd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in, pos_eff;
   logic [31:0] fmt_ff, fmt_in;
   logic [15:0] code_ff, code_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] size_ff, size_in;
   logic [32:0] left_ff, left_in;
   logic [7:0]  low_ff, low_in;
   logic        phase_ff, phase_in;
   logic        chn_ff, chn_in;

   logic               valid_ff, valid_in;
   kind_type           kind_ff, kind_in;
   logic signed [15:0] sample_ff, sample_in;
   logic               ochan_ff, ochan_in;
   logic [1:0]         numch_ff, numch_in;
   logic [31:0]        orate_ff, orate_in;
   err_type            err_ff, err_in;

   err_type     hdr_err;
   logic        narrow;
   logic        emit;
   logic        div_busy;
   logic        div_done;
   logic [31:0] quotient;

   wpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (size_in),
      .divisor  (align_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      pos_eff  = cmd.clear ? '0 : pos_ff;
      pos_in   = pos_ff;
      fmt_in   = fmt_ff;
      code_in  = code_ff;
      chan_in  = chan_ff;
      rate_in  = rate_ff;
      align_in = align_ff;
      bits_in  = bits_ff;
      size_in  = size_ff;
      left_in  = left_ff;
      low_in   = low_ff;
      phase_in = phase_ff;
      chn_in   = chn_ff;
      narrow   = bits_ff == 16'(BITS_NARROW);
      emit     = 1'b0;

      if (cmd.hdr_capture) begin
         pos_in = (pos_eff == POS_W'(HDR_LAST_POS)) ? pos_eff : pos_eff + POS_W'(1);
         unique case (pos_eff)
            POS_W'(FMT_SIZE_POS), POS_W'(FMT_SIZE_POS + 1),
            POS_W'(FMT_SIZE_POS + 2), POS_W'(FMT_SIZE_POS + 3):
               fmt_in = {data_byte, fmt_ff[31:8]};
            POS_W'(FMT_CODE_POS), POS_W'(FMT_CODE_POS + 1):
               code_in = {data_byte, code_ff[15:8]};
            POS_W'(CHAN_POS), POS_W'(CHAN_POS + 1):
               chan_in = {data_byte, chan_ff[15:8]};
            POS_W'(RATE_POS), POS_W'(RATE_POS + 1),
            POS_W'(RATE_POS + 2), POS_W'(RATE_POS + 3):
               rate_in = {data_byte, rate_ff[31:8]};
            POS_W'(ALIGN_POS), POS_W'(ALIGN_POS + 1):
               align_in = {data_byte, align_ff[15:8]};
            POS_W'(BITS_POS), POS_W'(BITS_POS + 1):
               bits_in = {data_byte, bits_ff[15:8]};
            POS_W'(SIZE_POS), POS_W'(SIZE_POS + 1),
            POS_W'(SIZE_POS + 2), POS_W'(SIZE_POS + 3):
               size_in = {data_byte, size_ff[31:8]};
            default: ;
         endcase
      end

      hdr_err = header_check(fmt_ff, code_ff, chan_ff, bits_ff, align_ff, size_in);

      if (cmd.clear || cmd.hdr_result) begin
         phase_in = 1'b0;
         chn_in   = 1'b0;
      end

      if (cmd.data_byte) begin
         if (narrow || phase_ff) begin
            emit     = 1'b1;
            phase_in = 1'b0;
         end else begin
            low_in   = data_byte;
            phase_in = 1'b1;
         end
      end

      if (emit) begin
         left_in = left_ff - 33'd1;
         if (chan_ff == 16'(MAX_CHANNELS)) chn_in = ~chn_ff;
      end

      if (div_done) begin
         unique case (chan_ff[1:0])
            2'd1:    left_in = {1'b0, quotient};
            2'd2:    left_in = {quotient, 1'b0};
            default: left_in = '0;
         endcase
      end

      valid_in  = valid_ff && !rsp_tready;
      kind_in   = kind_ff;
      sample_in = sample_ff;
      ochan_in  = ochan_ff;
      numch_in  = numch_ff;
      orate_in  = orate_ff;
      err_in    = err_ff;
      if (cmd.hdr_result || cmd.short_err || emit) begin
         valid_in  = 1'b1;
         kind_in   = KIND_SAMPLE;
         sample_in = '0;
         ochan_in  = 1'b0;
         numch_in  = '0;
         orate_in  = '0;
         err_in    = ERR_NONE;
         priority if (cmd.short_err) begin
            kind_in = KIND_REJECT;
            err_in  = ERR_SHORT;
         end else if (cmd.hdr_result) begin
            if (hdr_err == ERR_NONE) begin
               kind_in  = KIND_ACCEPT;
               numch_in = chan_ff[1:0];
               orate_in = rate_ff;
            end else begin
               kind_in = KIND_REJECT;
               err_in  = hdr_err;
            end
         end else begin
            sample_in = narrow ? {~data_byte[7], data_byte[6:0], 8'h00}
                               : {data_byte, low_ff};
            ochan_in  = chn_ff;
         end
      end

      status.out_free    = !valid_ff || rsp_tready;
      status.pos_end     = pos_ff == POS_W'(HDR_LAST_POS);
      status.hdr_ok      = hdr_err == ERR_NONE;
      status.emit_now    = narrow || phase_ff;
      status.samples_one = left_ff == 33'd1;
      status.div_busy    = div_busy;
      status.div_done    = div_done;
      status.count_zero  = (chan_ff[1:0] == 2'd0) || (quotient == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= 1'b0;
         chn_ff   <= 1'b0;
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         chn_ff   <= chn_in;
         left_ff  <= left_in;
         valid_ff <= valid_in;
      end
      fmt_ff    <= fmt_in;
      code_ff   <= code_in;
      chan_ff   <= chan_in;
      rate_ff   <= rate_in;
      align_ff  <= align_in;
      bits_ff   <= bits_in;
      size_ff   <= size_in;
      low_ff    <= low_in;
      kind_ff   <= kind_in;
      sample_ff <= sample_in;
      ochan_ff  <= ochan_in;
      numch_ff  <= numch_in;
      orate_ff  <= orate_in;
      err_ff    <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {2'b00, err_ff, orate_ff, numch_ff, ochan_ff, sample_ff};

endmodule

`default_nettype wire

// ----- src/wpd_ctrl.sv -----
// Controller state machine: tracks header, divide, data and done modes and
// issues datapath commands per accepted word. Depends on wpd_pkg.
`default_nettype none

module wpd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tlast,
   input  wire logic                   req_tuser,
   input  wire wpd_pkg::wpd_status_type status,
   output logic                        req_tready,
   output wpd_pkg::wpd_cmd_type        cmd
);
   import wpd_pkg::*;

   wpd_state_type state_ff, state_in;
   wpd_state_type mode;
   logic          accept;
   logic          pos_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HEADER;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_tready = (state_ff != ST_DIVIDE) && status.out_free;
      accept     = req_tvalid && req_tready;
      mode       = req_tuser ? ST_HEADER : state_ff;
      pos_end    = status.pos_end && !req_tuser;
      cmd        = '0;
      state_in   = state_ff;

      if (accept) begin
         cmd.clear = req_tuser;
         unique case (mode)
            ST_HEADER: begin
               cmd.hdr_capture = 1'b1;
               state_in        = ST_HEADER;
               if (pos_end) begin
                  cmd.hdr_result = 1'b1;
                  if (!status.hdr_ok || req_tlast) begin
                     state_in = ST_DONE;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = ST_DIVIDE;
                  end
               end else if (req_tlast) begin
                  cmd.short_err = 1'b1;
                  state_in      = ST_DONE;
               end
            end
            ST_DATA: begin
               cmd.data_byte = 1'b1;
               if ((status.emit_now && status.samples_one) || req_tlast) state_in = ST_DONE;
            end
            ST_DIVIDE, ST_DONE: state_in = mode;
         endcase
      end else if (state_ff == ST_DIVIDE && status.div_done) begin
         state_in = status.count_zero ? ST_DONE : ST_DATA;
      end
   end

endmodule

`default_nettype wire

// ----- src/wav_pcm_stream_decoder_top.sv -----
// WAV PCM stream decoder top level: joins the controller and the datapath.
// Depends on wpd_pkg, wpd_ctrl, wpd_datapath and wpd_div.
//
// The req channel carries a WAV file one byte per word; req_tuser marks the
// first byte of a file and restarts parsing, req_tlast marks its final byte.
// The first 44 bytes are the header. After byte 43 the rsp channel gives one
// header word (kind accepted with channel count and sample rate, or kind
// rejected with an error code); a file that ends inside the header gives a
// rejected word with the short error. Sample data then yields one Q1.15
// sample word per sample with its channel index, up to channels times
// data size over block align samples; later bytes are dropped.
// A word is taken each cycle while req_tready is high, and its result appears on rsp in the next cycle.
// After an accepted header the frame count comes from a 32-step divider,
// so req_tready stays low until the divider is done, before sample data is taken.
// req_tready also drops while a result waits on a stalled rsp_tready, since
// the single result register must drain first. Reset empties the result
// register and starts parsing at header byte 0.
`default_nettype none

module wav_pcm_stream_decoder_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [7:0]                       req_tdata,  // data_byte
   input  wire logic                             req_tuser,  // first_byte
   input  wire logic                             req_tlast,  // last_byte
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // sample_value[15:0], channel[16], num_channels[18:17], sample_rate[50:19],
   // error_code[53:51], zero fill[55:54]
   output logic [wpd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [1:0]                            rsp_tuser   // kind
);
   import wpd_pkg::*;

   wpd_cmd_type    cmd;
   wpd_status_type status;

   wpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   wpd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .data_byte  (req_tdata),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTH
   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_tready)
      else $error("input accepted while the frame count is being divided");

   a_reject_has_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_REJECT |-> rsp_tdata[53:51] != ERR_NONE)
      else $error("rejected header word without an error code");

   a_accept_channels: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ACCEPT |-> rsp_tdata[18:17] != 2'd3)
      else $error("accepted header word with an impossible channel count");

   a_divide_only_after_header: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> rsp_tvalid && rsp_tuser == KIND_ACCEPT)
      else $error("divider started without an accepted header word");
`endif

endmodule

`default_nettype wire
